>>> src/agpo_pkg.sv
// Shared constants, types and functions for the adaptive gait phase oscillator.
`timescale 1ns / 1ps
package agpo_pkg;

  localparam int unsigned CycleLimit  = 512;
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned SegPosW     = $clog2(CycleLimit + 1);
  localparam int unsigned StepW       = $clog2(CordicSteps + 1);

  localparam int unsigned CordW  = 48;
  localparam int unsigned ZW     = 24;
  localparam int unsigned DivW   = 29;

  localparam logic signed [ZW-1:0] PiQ20   = 24'sd3294199;
  localparam logic signed [15:0]   PiQ12   = 16'sd12868;
  localparam logic signed [15:0]   SegSeed = 16'sd25600;
  localparam logic [15:0]          GainOne = 16'd4096;
  localparam logic [15:0]          GainMax = 16'hFFFF;
  localparam logic [15:0]          RunMax  = 16'hFFFF;

  localparam logic [1:0] CfgJump   = 2'd0;
  localparam logic [1:0] CfgMinSeg = 2'd1;
  localparam logic [1:0] CfgStop   = 2'd2;
  localparam logic [1:0] CfgCount  = 2'd3;

  function automatic logic signed [ZW-1:0] atan_q20(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    begin
      unique case (i)
        5'd0:  r = 24'sd823550;
        5'd1:  r = 24'sd486170;
        5'd2:  r = 24'sd256879;
        5'd3:  r = 24'sd130396;
        5'd4:  r = 24'sd65451;
        5'd5:  r = 24'sd32757;
        5'd6:  r = 24'sd16383;
        5'd7:  r = 24'sd8192;
        5'd8:  r = 24'sd4096;
        5'd9:  r = 24'sd2048;
        5'd10: r = 24'sd1024;
        5'd11: r = 24'sd512;
        5'd12: r = 24'sd256;
        5'd13: r = 24'sd128;
        5'd14: r = 24'sd64;
        5'd15: r = 24'sd32;
        5'd16: r = 24'sd16;
        5'd17: r = 24'sd8;
        5'd18: r = 24'sd4;
        5'd19: r = 24'sd2;
        5'd20: r = 24'sd1;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage

>>> src/agpo_cordic.sv
// Iterative vectoring CORDIC atan2 with Q3.12 rounded, clamped result.
`timescale 1ns / 1ps
module agpo_cordic (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [47:0]   y_i,
  input  logic signed [47:0]   x_i,
  output logic                 done_o,
  output logic signed [14:0]   phase_o
);
  import agpo_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StNorm = 2'd1;
  localparam logic [1:0] StRot  = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  logic [1:0] state_q, state_d;
  logic signed [CordW-1:0] x_q, x_d, y_q, y_d;
  logic signed [ZW-1:0] z_q, z_d;
  logic [StepW-1:0] step_q, step_d;
  logic zero_q, zero_d;
  logic signed [14:0] phase_q, phase_d;
  logic done_q, done_d;

  logic signed [CordW-1:0] ax, ay, mag, dx, dy;
  logic signed [ZW+1:0] rsum;
  logic signed [ZW+1:0] rq;

  always_comb begin
    ax  = x_q[CordW-1] ? -x_q : x_q;
    ay  = y_q[CordW-1] ? -y_q : y_q;
    mag = (ax > ay) ? ax : ay;
    dx  = y_q >>> step_q;
    dy  = x_q >>> step_q;
    rsum = {{2{z_q[ZW-1]}}, z_q} + 26'sd128;
    rq   = rsum >>> 8;
  end

  always_comb begin
    state_d = state_q;
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    step_d = step_q;
    zero_d = zero_q;
    phase_d = phase_q;
    done_d = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          zero_d = (x_i == '0) && (y_i == '0);
          step_d = '0;
          if (x_i[47]) begin
            x_d = -x_i;
            y_d = -y_i;
            z_d = y_i[47] ? -PiQ20 : PiQ20;
          end else begin
            x_d = x_i;
            y_d = y_i;
            z_d = '0;
          end
          state_d = StNorm;
        end
      end
      StNorm: begin
        if (zero_q) begin
          state_d = StOut;
        end else if (mag < (48'sd1 <<< 40)) begin
          x_d = x_q <<< 1;
          y_d = y_q <<< 1;
        end else begin
          state_d = StRot;
        end
      end
      StRot: begin
        if (!y_q[CordW-1]) begin
          x_d = x_q + dx;
          y_d = y_q - dy;
          z_d = z_q + atan_q20(5'(step_q));
        end else begin
          x_d = x_q - dx;
          y_d = y_q + dy;
          z_d = z_q - atan_q20(5'(step_q));
        end
        step_d = step_q + 1'b1;
        if (step_q == StepW'(CordicSteps - 1)) state_d = StOut;
      end
      StOut: begin
        if (zero_q) begin
          phase_d = '0;
        end else if (rq > 26'(PiQ12)) begin
          phase_d = 15'(PiQ12);
        end else if (rq < -26'(PiQ12)) begin
          phase_d = -15'(PiQ12);
        end else begin
          phase_d = 15'(rq);
        end
        done_d = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
    step_q <= step_d;
    zero_q <= zero_d;
    phase_q <= phase_d;
  end

  assign done_o  = done_q;
  assign phase_o = phase_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == StIdle) else $error("done outside idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (phase_q <= 15'(PiQ12)) && (phase_q >= -15'(PiQ12)))
    else $error("phase out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRot |-> step_q < StepW'(CordicSteps)) else $error("step overrun");
endmodule

>>> src/adaptive_gait_phase_oscillator.sv
// Top level: gait phase estimator with shared CORDIC and serial divider.
`timescale 1ns / 1ps
// One sample is taken at a time. Each sample runs the shared CORDIC twice
// (raw phase, then adjusted phase), each run taking up to 40 normalize shifts
// plus 16 rotation steps, or neither when both operands are zero; a cycle
// boundary with a gain update adds a restoring divide for the gain. The
// result sits in an output register, and the next sample is taken once it
// has been accepted.
module adaptive_gait_phase_oscillator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic signed [15:0]  joint_angle_i,
  input  logic signed [15:0]  joint_velocity_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic signed [14:0]  adjusted_phase_o,
  output logic                walking_o,
  output logic                cycle_start_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [16:0]         cfg_data_i
);
  import agpo_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRaw  = 3'd1;
  localparam logic [2:0] StDec  = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StMul  = 3'd4;
  localparam logic [2:0] StAdj  = 3'd5;
  localparam logic [2:0] StFin  = 3'd6;
  localparam logic [2:0] StOut  = 3'd7;

  logic [2:0] state_q, state_d;
  logic [14:0] thr_q;
  logic [8:0]  minseg_q;
  logic [16:0] sspan_q;
  logic [14:0] scount_q;

  logic signed [15:0] a_q, v_q;
  logic tracking_q, prev_valid_q, empty_q;
  logic signed [15:0] prev_raw_q;
  logic [SegPosW-1:0] segpos_q;
  logic signed [15:0] amax_q, amin_q, vmax_q, vmin_q;
  logic [15:0] gain_q;
  logic signed [15:0] vc_q, ac_q;
  logic signed [16:0] adj_max_q, adj_min_q;
  logic [15:0] run_q;
  logic start_q;
  logic upd_q;

  logic [DivW-1:0] rem_q, quo_q;
  logic [16:0] dvs_q;
  logic [4:0] dcnt_q;

  logic cstart;
  logic signed [47:0] cy, cx;
  logic cdone;
  logic signed [14:0] cphase;

  logic signed [14:0] out_phase_q;
  logic out_walk_q, out_start_q, valid_q;

  agpo_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cstart),
    .y_i    (cy),
    .x_i    (cx),
    .done_o (cdone),
    .phase_o(cphase)
  );

  logic signed [16:0] raw_diff;
  logic jump;
  logic signed [16:0] adj_angle, vdiff;
  logic signed [16:0] nmax, nmin;
  logic [16:0] span;
  logic [DivW:0] rem_sh;
  logic signed [33:0] prod;

  always_comb begin
    raw_diff = 17'(cphase) - 17'(prev_raw_q);
    jump = prev_valid_q && (raw_diff > $signed({2'b00, thr_q}));
    adj_angle = 17'(a_q) - 17'(ac_q);
    vdiff = 17'(v_q) - 17'(vc_q);
    prod = $signed({1'b0, gain_q}) * vdiff;
    nmax = (empty_q || adj_angle > adj_max_q) ? adj_angle : adj_max_q;
    nmin = (empty_q || adj_angle < adj_min_q) ? adj_angle : adj_min_q;
    span = 17'(nmax - nmin);
    rem_sh = {rem_q, quo_q[DivW-1]};
  end

  assign cstart = (state_q == StIdle && valid_i && !valid_q) || (state_q == StMul);
  assign cy = (state_q == StMul) ? 48'(prod) : 48'(joint_velocity_i);
  assign cx = (state_q == StMul) ? 48'(adj_angle) <<< 12 : 48'(joint_angle_i);
  assign ready_o = (state_q == StIdle) && !valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      thr_q <= 15'd4096;
      minseg_q <= 9'd8;
      sspan_q <= 17'd2560;
      scount_q <= 15'd10;
      tracking_q <= 1'b0;
      prev_valid_q <= 1'b0;
      prev_raw_q <= '0;
      segpos_q <= '0;
      amax_q <= -SegSeed;
      amin_q <= SegSeed;
      vmax_q <= -SegSeed;
      vmin_q <= SegSeed;
      gain_q <= GainOne;
      vc_q <= '0;
      ac_q <= '0;
      empty_q <= 1'b1;
      run_q <= '0;
      valid_q <= 1'b0;
      start_q <= 1'b0;
      upd_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgJump:   thr_q <= cfg_data_i[14:0];
          CfgMinSeg: minseg_q <= cfg_data_i[8:0];
          CfgStop:   sspan_q <= cfg_data_i;
          CfgCount:  scount_q <= cfg_data_i[14:0];
          default: ;
        endcase
      end
      if (valid_q && ready_i) valid_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (valid_i && !valid_q) begin
            a_q <= joint_angle_i;
            v_q <= joint_velocity_i;
            state_q <= StRaw;
          end
        end
        StRaw: begin
          if (cdone) begin
            prev_raw_q <= 16'(cphase);
            prev_valid_q <= 1'b1;
            start_q <= 1'b0;
            upd_q <= 1'b0;
            state_q <= StDec;
            if (!tracking_q) begin
              if (jump) begin
                tracking_q <= 1'b1;
                start_q <= 1'b1;
              end
            end else if (jump && segpos_q > SegPosW'(minseg_q)) begin
              start_q <= 1'b1;
              upd_q <= 1'b1;
              vc_q <= 16'((17'(vmax_q) + 17'(vmin_q)) >>> 1);
              ac_q <= 16'((17'(amax_q) + 17'(amin_q)) >>> 1);
              rem_q <= '0;
              quo_q <= DivW'(17'(amax_q) - 17'(amin_q)) << 12;
              dvs_q <= 17'(vmax_q) - 17'(vmin_q);
              dcnt_q <= '0;
              state_q <= StDiv;
            end
          end
        end
        StDiv: begin
          if (rem_sh >= (DivW + 1)'(dvs_q)) begin
            rem_q <= DivW'(rem_sh - (DivW + 1)'(dvs_q));
            quo_q <= {quo_q[DivW-2:0], 1'b1};
          end else begin
            rem_q <= DivW'(rem_sh);
            quo_q <= {quo_q[DivW-2:0], 1'b0};
          end
          dcnt_q <= dcnt_q + 1'b1;
          if (dcnt_q == 5'(DivW - 1)) state_q <= StDec;
        end
        StDec: begin
          if (start_q) begin
            if (upd_q)
              gain_q <= (dvs_q == '0 || quo_q > DivW'(GainMax)) ? GainMax : quo_q[15:0];
            amax_q <= (a_q > -SegSeed) ? a_q : -SegSeed;
            amin_q <= (a_q < SegSeed) ? a_q : SegSeed;
            vmax_q <= (v_q > -SegSeed) ? v_q : -SegSeed;
            vmin_q <= (v_q < SegSeed) ? v_q : SegSeed;
            segpos_q <= '0;
            empty_q <= 1'b1;
          end else begin
            if (a_q > amax_q) amax_q <= a_q;
            if (a_q < amin_q) amin_q <= a_q;
            if (v_q > vmax_q) vmax_q <= v_q;
            if (v_q < vmin_q) vmin_q <= v_q;
          end
          state_q <= StMul;
        end
        StMul: state_q <= StAdj;
        StAdj: begin
          if (cdone) begin
            out_phase_q <= cphase;
            state_q <= StFin;
          end
        end
        StFin: begin
          adj_max_q <= nmax;
          adj_min_q <= nmin;
          empty_q <= 1'b0;
          if (span <= sspan_q) begin
            if (run_q != RunMax) run_q <= run_q + 1'b1;
          end else begin
            run_q <= '0;
          end
          if (segpos_q + 1'b1 >= SegPosW'(CycleLimit)) begin
            segpos_q <= '0;
            tracking_q <= 1'b0;
            prev_valid_q <= 1'b0;
            amax_q <= -SegSeed;
            amin_q <= SegSeed;
            vmax_q <= -SegSeed;
            vmin_q <= SegSeed;
          end else begin
            segpos_q <= segpos_q + 1'b1;
          end
          state_q <= StOut;
        end
        StOut: begin
          out_walk_q <= !((span <= sspan_q) ?
                          ((run_q) > 16'(scount_q)) : 1'b0);
          out_start_q <= start_q;
          valid_q <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign valid_o = valid_q;
  assign adjusted_phase_o = out_phase_q;
  assign walking_o = out_walk_q;
  assign cycle_start_o = out_start_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> state_q == StIdle || state_q == StOut || state_q == StFin
    || state_q == StAdj || state_q == StMul || state_q == StDec
    || state_q == StRaw || state_q == StDiv) else $error("bad state");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_o |-> !valid_q) else $error("ready with pending result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StOut |=> valid_q) else $error("result lost");
endmodule

>>> sim/adaptive_gait_phase_oscillator_test.sv
// Self-checking testbench for the adaptive gait phase oscillator.
`timescale 1ns / 1ps
module adaptive_gait_phase_oscillator_test;
  import agpo_pkg::*;

  typedef struct {
    logic signed [15:0] angle;
    logic signed [15:0] vel;
  } sample_t;

  typedef struct {
    logic signed [14:0] phase;
    logic               walking;
    logic               cycle_start;
  } phase_beat_t;

  localparam int WatchLimit = 4000;
  localparam int DrainWait  = 300;
  localparam longint PiRad20 = 3294199;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               valid_i = 1'b0;
  logic               ready_o;
  logic signed [15:0] joint_angle_i = '0;
  logic signed [15:0] joint_velocity_i = '0;
  logic               valid_o;
  logic               ready_i = 1'b0;
  logic signed [14:0] adjusted_phase_o;
  logic               walking_o;
  logic               cycle_start_o;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_index_i = CfgJump;
  logic [16:0]        cfg_data_i = '0;

  sample_t     sample_q[$];
  phase_beat_t phase_q[$];
  logic        sample_taken = 1'b0;
  logic        no_idle = 1'b0;
  int          fail_cnt = 0;
  int          quiet_cycles = 0;

  longint atan_tbl [16] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
                            4096, 2048, 1024, 512, 256, 128, 64, 32};

  logic [14:0]        m_jump;
  logic [8:0]         m_min_seg;
  logic [16:0]        m_stop_span;
  logic [14:0]        m_stop_count;
  logic               m_tracking, m_prev_valid, m_ext_empty;
  logic signed [15:0] m_prev_raw;
  logic [9:0]         m_seg_pos;
  logic signed [15:0] m_amax, m_amin, m_vmax, m_vmin;
  logic [15:0]        m_gain;
  logic signed [15:0] m_vcen, m_acen;
  logic signed [16:0] m_adj_max, m_adj_min;
  logic [15:0]        m_small_run;

  adaptive_gait_phase_oscillator DUT (
    .clk_i, .rst_ni, .valid_i, .ready_o, .joint_angle_i, .joint_velocity_i,
    .valid_o, .ready_i, .adjusted_phase_o, .walking_o, .cycle_start_o,
    .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  always #1 clk_i = ~clk_i;

  function automatic int cordic_phase(longint y, longint x);
    longint base, z, mag, ay, dx, dy, r;
    if (x == 0 && y == 0) return 0;
    base = 0;
    z = 0;
    if (x < 0) begin
      base = (y >= 0) ? PiRad20 : -PiRad20;
      x = -x;
      y = -y;
    end
    ay = (y < 0) ? -y : y;
    mag = (x > ay) ? x : ay;
    while (mag < (64'sd1 <<< 40)) begin
      x = x * 2;
      y = y * 2;
      mag = mag * 2;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx; y = y - dy; z = z + atan_tbl[i];
      end else begin
        x = x - dx; y = y + dy; z = z - atan_tbl[i];
      end
    end
    r = (base + z + 128) >>> 8;
    if (r > 12868) r = 12868;
    if (r < -12868) r = -12868;
    return int'(r);
  endfunction

  function automatic void reseed_extrema();
    m_amax = -SegSeed;
    m_amin = SegSeed;
    m_vmax = -SegSeed;
    m_vmin = SegSeed;
  endfunction

  function automatic phase_beat_t predict_phase(sample_t s);
    phase_beat_t e;
    int a, v, raw, adj, ph;
    longint aspan, vspan, q, span;
    logic jump, start;
    a = s.angle;
    v = s.vel;
    raw = cordic_phase(longint'(v), longint'(a));
    jump = m_prev_valid && (raw - int'(m_prev_raw) > int'(m_jump));
    start = 1'b0;
    if (!m_tracking) begin
      if (jump) begin
        m_tracking = 1'b1;
        start = 1'b1;
      end
    end else if (jump && m_seg_pos > m_min_seg) begin
      aspan = longint'(m_amax) - longint'(m_amin);
      vspan = longint'(m_vmax) - longint'(m_vmin);
      if (vspan == 0) m_gain = GainMax;
      else begin
        q = (aspan << 12) / vspan;
        m_gain = (q > 65535) ? GainMax : q[15:0];
      end
      m_vcen = 16'((longint'(m_vmax) + longint'(m_vmin)) >>> 1);
      m_acen = 16'((longint'(m_amax) + longint'(m_amin)) >>> 1);
      start = 1'b1;
    end
    if (start) begin
      reseed_extrema();
      m_seg_pos = '0;
      m_ext_empty = 1'b1;
    end
    if (a > m_amax) m_amax = 16'(a);
    if (a < m_amin) m_amin = 16'(a);
    if (v > m_vmax) m_vmax = 16'(v);
    if (v < m_vmin) m_vmin = 16'(v);
    m_prev_raw = 16'(raw);
    m_prev_valid = 1'b1;
    adj = a - int'(m_acen);
    ph = cordic_phase(longint'(m_gain) * longint'(v - int'(m_vcen)), longint'(adj) * 4096);
    if (m_ext_empty) begin
      m_adj_max = 17'(adj);
      m_adj_min = 17'(adj);
      m_ext_empty = 1'b0;
    end else begin
      if (adj > m_adj_max) m_adj_max = 17'(adj);
      if (adj < m_adj_min) m_adj_min = 17'(adj);
    end
    span = longint'(m_adj_max) - longint'(m_adj_min);
    if (span <= longint'(m_stop_span)) begin
      if (m_small_run != RunMax) m_small_run++;
    end else begin
      m_small_run = '0;
    end
    m_seg_pos++;
    if (m_seg_pos >= CycleLimit) begin
      m_seg_pos = '0;
      m_tracking = 1'b0;
      m_prev_valid = 1'b0;
      reseed_extrema();
    end
    e.phase = 15'(ph);
    e.walking = (m_small_run > m_stop_count) ? 1'b0 : 1'b1;
    e.cycle_start = start;
    return e;
  endfunction

  function automatic logic signed [15:0] clip16(real r);
    int c;
    c = $rtoi(r);
    if (c > 32767) c = 32767;
    if (c < -32768) c = -32768;
    return 16'(c);
  endfunction

  task automatic add_sample(int a, int v);
    sample_t s;
    s.angle = 16'(a);
    s.vel = 16'(v);
    sample_q.push_back(s);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [16:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CfgJump:   m_jump = val[14:0];
      CfgMinSeg: m_min_seg = val[8:0];
      CfgStop:   m_stop_span = val;
      CfgCount:  m_stop_count = val[14:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly clean gait cycles of random size, some noise and broken cycles.
  task automatic add_gait(int count);
    real th, step, amp_a, amp_v, off_a, off_v;
    int n;
    n = 0;
    while (n < count) begin
      step = 6.2832 / $urandom_range(6, 60);
      amp_a = $urandom_range(50, 30000);
      amp_v = $urandom_range(50, 30000);
      off_a = $itor($urandom_range(0, 2000)) - 1000.0;
      off_v = $itor($urandom_range(0, 2000)) - 1000.0;
      th = $itor($urandom_range(0, 628)) / 100.0;
      repeat ($urandom_range(1, 4)) begin
        while (th < 6.2832 && n < count) begin
          if ($urandom_range(0, 99) < 8)
            add_sample(int'($urandom()) % 65536 - 32768, int'($urandom()) % 65536 - 32768);
          else
            add_sample(clip16(off_a + amp_a * $cos(th) + $urandom_range(0, 40) - 20),
                       clip16(off_v - amp_v * $sin(th) + $urandom_range(0, 40) - 20));
          th = th + step;
          n++;
        end
        th = th - 6.2832;
      end
    end
  endtask

  task automatic drain();
    while (sample_q.size() != 0 || valid_i || phase_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    phase_beat_t e;
    sample_t s;
    sample_taken <= valid_i && ready_o;
    if (valid_i && ready_o) begin
      s.angle = joint_angle_i;
      s.vel = joint_velocity_i;
      phase_q.push_back(predict_phase(s));
    end
    if (valid_o && ready_i) begin
      if (phase_q.size() == 0) begin
        $error("unexpected beat phase=%0d", adjusted_phase_o);
        fail_cnt++;
      end else begin
        e = phase_q.pop_front();
        if (adjusted_phase_o !== e.phase) begin
          $error("adjusted_phase expected %0d got %0d", e.phase, adjusted_phase_o);
          fail_cnt++;
        end
        if (walking_o !== e.walking) begin
          $error("walking expected %0b got %0b", e.walking, walking_o);
          fail_cnt++;
        end
        if (cycle_start_o !== e.cycle_start) begin
          $error("cycle_start expected %0b got %0b", e.cycle_start, cycle_start_o);
          fail_cnt++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    sample_t s;
    if (rst_ni && (!valid_i || sample_taken)) begin
      if (sample_q.size() != 0 && (no_idle || $urandom_range(0, 99) >= 27)) begin
        s = sample_q.pop_front();
        valid_i <= 1'b1;
        joint_angle_i <= s.angle;
        joint_velocity_i <= s.vel;
      end else begin
        valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    ready_i <= no_idle || ($urandom_range(0, 99) >= 27);
  end

  always @(posedge clk_i) begin
    if ((valid_i && ready_o) || (valid_o && ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    m_jump = 15'd4096;
    m_min_seg = 9'd8;
    m_stop_span = 17'd2560;
    m_stop_count = 15'd10;
    m_tracking = 1'b0;
    m_prev_valid = 1'b0;
    m_prev_raw = '0;
    m_seg_pos = '0;
    reseed_extrema();
    m_gain = GainOne;
    m_vcen = '0;
    m_acen = '0;
    m_adj_max = '0;
    m_adj_min = '0;
    m_ext_empty = 1'b1;
    m_small_run = '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // extremes, quadrants, zero operands, wrap jump
    add_sample(0, 0);
    add_sample(32767, 32767);
    add_sample(-32768, -32768);
    add_sample(-32768, 32767);
    add_sample(32767, -32768);
    add_sample(-32768, 0);
    add_sample(-1, -1);
    add_sample(0, 32767);
    add_sample(0, -32768);
    add_sample(-100, 1);
    add_sample(-100, -1);
    add_sample(-100, 1);
    add_sample(1, 0);
    add_sample(-21846, 21845);
    add_sample(21845, -21846);
    add_sample(0, 0);
    // segment overflow: no boundary for longer than the cycle limit
    repeat (CycleLimit + 8) add_sample(300, 0);
    no_idle = 1'b1;
    drain();
    no_idle = 1'b0;

    add_gait(300);
    drain();

    write_reg(CfgJump, 17'd0);
    write_reg(CfgMinSeg, 17'd1);
    write_reg(CfgStop, 17'd0);
    write_reg(CfgCount, 17'd0);
    add_gait(300);
    // flat velocity segments: zero velocity apart from the boundary sample
    repeat (6) begin
      repeat (5) add_sample(2000, 0);
      add_sample(-2000, 1);
    end
    drain();

    write_reg(CfgJump, 17'd32767);
    write_reg(CfgMinSeg, 17'd511);
    write_reg(CfgStop, 17'd131071);
    write_reg(CfgCount, 17'd32767);
    add_gait(260);
    drain();

    write_reg(CfgJump, 17'd25736);
    write_reg(CfgMinSeg, 17'd2);
    write_reg(CfgStop, 17'd300);
    write_reg(CfgCount, 17'd3);
    add_gait(260);
    drain();

    write_reg(CfgJump, 17'($urandom_range(0, 32767)));
    write_reg(CfgMinSeg, 17'($urandom_range(0, 40)));
    write_reg(CfgStop, 17'($urandom_range(0, 131071)));
    write_reg(CfgCount, 17'($urandom_range(0, 100)));
    add_gait(260);
    drain();

    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
